// File: src/utf8_text_layout_cursor_unit_defines.svh
// Assertion macros shared by the text layout cursor RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef UTF8_TEXT_LAYOUT_CURSOR_UNIT_DEFINES_SVH
`define UTF8_TEXT_LAYOUT_CURSOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UTLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("utlc check failed");

// Next-cycle implication, disabled while in reset.
`define UTLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("utlc check failed");

`endif

// File: src/utlc_pkg.sv
// Types and constants for the UTF-8 text layout cursor.
// No dependencies; used by the interfaces and the top level.
package utlc_pkg;

	localparam logic [11:0] ROW_MAX      = 12'hFFF;
	localparam logic [7:0]  CHAR_LF      = 8'h0A;
	localparam logic [7:0]  LEAD3_MASK   = 8'hE0;
	localparam int unsigned SW_W         = 10;
	localparam int unsigned FS_W         = 8;
	localparam int unsigned COL_W        = 11;
	localparam int unsigned ROW_W        = 12;
	localparam int unsigned CP_W         = 16;
	localparam int unsigned CFG_DATA_W   = 10;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH = 1'b0,
		REG_FONT_SIZE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_START = 1'b0,
		KIND_TEXT  = 1'b1
	} item_kind_t;

endpackage

// File: src/utlc_ifs.sv
// Handshake channel interfaces for the text layout cursor.
// Depends on utlc_pkg for field widths.
interface utlc_in_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [7:0]                       data_byte;
	logic [9:0]                       start_x;
	logic [utlc_pkg::ROW_W-1:0]       start_y;
	modport source (output valid, kind, data_byte, start_x, start_y, input ready);
	modport sink   (input valid, kind, data_byte, start_x, start_y, output ready);
endinterface

interface utlc_out_if;
	logic                             valid;
	logic                             ready;
	logic [utlc_pkg::CP_W-1:0]        code_point;
	logic                             is_wide;
	logic [9:0]                       pos_x;
	logic [utlc_pkg::ROW_W-1:0]       pos_y;
	modport source (output valid, code_point, is_wide, pos_x, pos_y, input ready);
	modport sink   (input valid, code_point, is_wide, pos_x, pos_y, output ready);
endinterface

interface utlc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [0:0]                       index;
	logic [utlc_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: src/utf8_text_layout_cursor_unit.sv
// UTF-8 decoder and text cursor with line wrap: top level.
// Depends on utlc_pkg, utlc_ifs.sv and utf8_text_layout_cursor_unit_defines.svh.
//
//  channel    dir  word carried                               accepted when
//  cfg        in   index, data (screen_width / font_size)     cfg.valid & cfg.ready
//  text_in    in   kind, data_byte, start_x, start_y          text_in.valid & text_in.ready
//  glyph_out  out  code_point, is_wide, pos_x, pos_y          glyph_out.valid & glyph_out.ready
//
// One word per cycle sustained while glyph_out takes each result. A word is
// registered in the input stage (_s1), and its glyph, if any, is then
// registered in the result register, which drives glyph_out. The decode and cursor
// update (one add/compare for the wrap test, one saturating add for the row)
// sit between those two registers.
// Reset clears the cursor, decoder and config to their reset values at once.
// A stalled result blocks only a word that makes a glyph; start words, lead
// bytes and newlines keep moving. cfg.ready is always high.
`include "utf8_text_layout_cursor_unit_defines.svh"

module utf8_text_layout_cursor_unit (
	input  logic          clk,
	input  logic          arst_n,
	utlc_cfg_if.sink      cfg,
	utlc_in_if.sink       text_in,
	utlc_out_if.source    glyph_out
);

	// Config registers
	logic [utlc_pkg::SW_W-1:0]  screen_width_q;
	logic [utlc_pkg::FS_W-1:0]  font_size_q;

	// Input stage
	logic                       valid_s1;
	logic                       kind_s1;
	logic [7:0]                 byte_s1;
	logic [9:0]                 start_x_s1;
	logic [utlc_pkg::ROW_W-1:0] start_y_s1;

	// Cursor / decoder state
	logic [utlc_pkg::COL_W-1:0] col_q;
	logic [utlc_pkg::ROW_W-1:0] row_q;
	logic [9:0]                 origin_q;
	logic [1:0]                 pend_q;
	logic [utlc_pkg::CP_W-1:0]  accum_q;

	// Result register
	logic                       out_valid_q;
	logic [utlc_pkg::CP_W-1:0]  code_q;
	logic                       wide_q;
	logic [9:0]                 pos_x_q;
	logic [utlc_pkg::ROW_W-1:0] pos_y_q;

	// Next-state logic
	logic                       emit;
	logic                       wrap;
	logic                       out_free;
	logic                       adv_s1;
	logic [utlc_pkg::COL_W-1:0] col_d;
	logic [utlc_pkg::ROW_W-1:0] row_d;
	logic [9:0]                 origin_d;
	logic [1:0]                 pend_d;
	logic [utlc_pkg::CP_W-1:0]  accum_d;
	logic [utlc_pkg::CP_W-1:0]  code_d;
	logic                       wide_d;
	logic [9:0]                 pos_x_d;
	logic [utlc_pkg::ROW_W-1:0] pos_y_d;

	// Shared glyph-place datapath
	logic [utlc_pkg::CP_W-1:0]  acc_shift;
	logic [1:0]                 pend_dec;
	logic                       place_wide;
	logic [utlc_pkg::FS_W-1:0]  glyph_w;
	logic [utlc_pkg::ROW_W:0]   col_sum;
	logic [utlc_pkg::ROW_W:0]   row_sum;
	logic [utlc_pkg::ROW_W-1:0] row_step;
	logic [utlc_pkg::COL_W-1:0] org_sum;

	assign out_free = !out_valid_q || glyph_out.ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign text_in.ready = !valid_s1 || adv_s1;
	assign cfg.ready     = 1'b1;

	assign glyph_out.valid      = out_valid_q;
	assign glyph_out.code_point = code_q;
	assign glyph_out.is_wide    = wide_q;
	assign glyph_out.pos_x      = pos_x_q;
	assign glyph_out.pos_y      = pos_y_q;

	// Continuation byte folds six more bits into the code point
	assign acc_shift = {accum_q[utlc_pkg::CP_W-7:0], byte_s1[5:0]};
	assign pend_dec  = pend_q - 2'd1;

	// Only finished multi-byte sequences are wide
	assign place_wide = (pend_q != 2'd0);
	assign glyph_w    = place_wide ? font_size_q : (font_size_q >> 1);

	// Wrap test at full width, row step saturates
	assign col_sum  = (utlc_pkg::ROW_W + 1)'(col_q) + (utlc_pkg::ROW_W + 1)'(glyph_w);
	assign wrap     = col_sum > (utlc_pkg::ROW_W + 1)'(screen_width_q);
	assign row_sum  = (utlc_pkg::ROW_W + 1)'(row_q) + (utlc_pkg::ROW_W + 1)'(font_size_q);
	assign row_step = row_sum[utlc_pkg::ROW_W] ? utlc_pkg::ROW_MAX
		: row_sum[utlc_pkg::ROW_W-1:0];
	assign org_sum  = utlc_pkg::COL_W'(origin_q) + utlc_pkg::COL_W'(glyph_w);

	always_comb begin
		col_d    = col_q;
		row_d    = row_q;
		origin_d = origin_q;
		pend_d   = pend_q;
		accum_d  = accum_q;
		emit     = 1'b0;
		code_d   = utlc_pkg::CP_W'(byte_s1);
		wide_d   = place_wide;
		pos_x_d  = wrap ? origin_q : col_q[9:0];
		pos_y_d  = wrap ? row_step : row_q;
		if (kind_s1 == utlc_pkg::KIND_START) begin
			col_d    = utlc_pkg::COL_W'(start_x_s1);
			origin_d = start_x_s1;
			row_d    = start_y_s1;
			pend_d   = 2'd0;
			accum_d  = '0;
		end else if (pend_q != 2'd0) begin
			accum_d = acc_shift;
			pend_d  = pend_dec;
			code_d  = acc_shift;
			if (pend_dec == 2'd0) begin
				emit  = 1'b1;
				row_d = pos_y_d;
				col_d = wrap ? org_sum : col_sum[utlc_pkg::COL_W-1:0];
			end
		end else if (!byte_s1[7]) begin
			if (byte_s1 == utlc_pkg::CHAR_LF) begin
				// Newline: wrap unconditionally, no glyph
				row_d = row_step;
				col_d = utlc_pkg::COL_W'(origin_q);
			end else begin
				emit  = 1'b1;
				row_d = pos_y_d;
				col_d = wrap ? org_sum : col_sum[utlc_pkg::COL_W-1:0];
			end
		end else if ((byte_s1 & utlc_pkg::LEAD3_MASK) == utlc_pkg::LEAD3_MASK) begin
			accum_d = utlc_pkg::CP_W'(byte_s1[3:0]);
			pend_d  = 2'd2;
		end else begin
			// Any other high byte, stray continuation too, leads a pair
			accum_d = utlc_pkg::CP_W'(byte_s1[4:0]);
			pend_d  = 2'd1;
		end
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= 10'd135;
			font_size_q    <= 8'd16;
		end else if (cfg.valid && cfg.ready) begin
			unique case (utlc_pkg::cfg_reg_t'(cfg.index))
				utlc_pkg::REG_SCREEN_WIDTH: screen_width_q <= cfg.data;
				utlc_pkg::REG_FONT_SIZE:    font_size_q    <= cfg.data[utlc_pkg::FS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			kind_s1    <= text_in.kind;
			byte_s1    <= text_in.data_byte;
			start_x_s1 <= text_in.start_x;
			start_y_s1 <= text_in.start_y;
		end
	end

	// Cursor and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			origin_q <= '0;
			pend_q   <= '0;
			accum_q  <= '0;
		end else if (adv_s1) begin
			col_q    <= col_d;
			row_q    <= row_d;
			origin_q <= origin_d;
			pend_q   <= pend_d;
			accum_q  <= accum_d;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			code_q  <= code_d;
			wide_q  <= wide_d;
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
		end
	end

	// Decoder never counts more than two continuation bytes
	`UTLC_ASSERT_NOW(a_pend_range, clk, arst_n, 1'b1, pend_q != 2'd3)
	// A start word always drops a partial sequence
	`UTLC_ASSERT_NEXT(a_start_clears, clk, arst_n,
		adv_s1 && (kind_s1 == utlc_pkg::KIND_START), pend_q == 2'd0)
	// A wrapped glyph lands at the line origin
	`UTLC_ASSERT_NEXT(a_wrap_origin, clk, arst_n,
		adv_s1 && emit && wrap, pos_x_q == $past(origin_q))
	// Input is only held off by a word waiting in the first stage
	`UTLC_ASSERT_NOW(a_ready_cause, clk, arst_n, !text_in.ready, valid_s1 && emit)

endmodule
